// ===== design/scrw_pkg.sv =====
`timescale 1ns / 1ps
package scrw_pkg;

	localparam int Q_W   = 16;
	localparam int MAG_W = 15;
	localparam int Q_ONE = 16384;

	localparam logic OP_PACKET = 1'b0;
	localparam logic OP_TICK   = 1'b1;

	localparam logic [7:0] PACKET_LEN = 8'd3;

	localparam logic [1:0] REG_SLEW_RATE     = 2'd0;
	localparam logic [1:0] REG_DEADZONE_RAW  = 2'd1;
	localparam logic [1:0] REG_TIMEOUT_TICKS = 2'd2;

	localparam logic [14:0] SLEW_RATE_RST     = 15'd819;
	localparam logic [6:0]  DEADZONE_RAW_RST  = 7'd7;
	localparam logic [15:0] TIMEOUT_TICKS_RST = 16'd50;

	typedef logic [MAG_W-1:0] goal_tab_t [256];

	typedef struct packed {
		logic                  accepted;
		logic signed [Q_W-1:0] goal_left;
		logic signed [Q_W-1:0] goal_right;
	} pkt_res_t;

	// round(m * 1.0 / 127) in Q1.14, clamped to 1.0
	function automatic goal_tab_t build_goal_table();
		goal_tab_t   t;
		int unsigned q;
		for (int i = 0; i < 256; i++) begin
			q = (i * Q_ONE + 63) / 127;
			if (q > Q_ONE)
				q = Q_ONE;
			t[i] = MAG_W'(q);
		end
		return t;
	endfunction

	localparam goal_tab_t GOAL_TABLE = build_goal_table();

	function automatic logic signed [Q_W-1:0] stick_goal(logic [7:0] b, logic [6:0] dz);
		logic [7:0]       m;
		logic [MAG_W-1:0] mag;
		logic [Q_W-1:0]   res;
		m   = b[7] ? 8'(-b) : b;
		mag = GOAL_TABLE[m];
		if (m < {1'b0, dz})
			res = '0;
		else if (b[7])
			res = Q_W'(-{1'b0, mag});
		else
			res = {1'b0, mag};
		return signed'(res);
	endfunction

endpackage

// ===== design/scrw_packet.sv =====
`timescale 1ns / 1ps
module scrw_packet
	import scrw_pkg::*;
(
	input  logic [7:0] payload_length,
	input  logic [7:0] left_command,
	input  logic [7:0] right_command,
	input  logic [7:0] check_byte,
	input  logic [6:0] deadzone,
	output pkt_res_t   res
);

	always_comb begin
		res.accepted   = (payload_length == PACKET_LEN) &&
		                 ((left_command ^ right_command) == check_byte);
		res.goal_left  = stick_goal(left_command, deadzone);
		res.goal_right = stick_goal(right_command, deadzone);
	end

endmodule

// ===== design/scrw_slew.sv =====
`timescale 1ns / 1ps
module scrw_slew
	import scrw_pkg::*;
(
	input  logic signed [Q_W-1:0] level,
	input  logic signed [Q_W-1:0] goal,
	input  logic [14:0]           step,
	output logic signed [Q_W-1:0] result
);

	logic signed [17:0] lvl_x;
	logic signed [17:0] goal_x;
	logic signed [17:0] step_x;
	logic signed [17:0] up;
	logic signed [17:0] dn;

	assign lvl_x  = 18'(level);
	assign goal_x = 18'(goal);
	assign step_x = {3'b000, step};
	assign up     = lvl_x + step_x;
	assign dn     = lvl_x - step_x;

	always_comb begin
		result = level;
		if (level < goal) begin
			result = (up > goal_x) ? goal : up[Q_W-1:0];
		end else if (level > goal) begin
			result = (dn < goal_x) ? goal : dn[Q_W-1:0];
		end
	end

endmodule

// ===== design/stick_command_ramp_watchdog.sv =====
`timescale 1ns / 1ps
// an accepted item passes through the input register, then the result register
// throughput: one item per cycle while results are taken; state updates as an item moves into
// the result register; a stalled result holds, and an empty input register takes an item
// reset (arst_n low, async): goals, levels, torque, watchdog and tick count clear,
// registers return to slew rate 819, deadzone_raw 7, timeout_ticks 50
module stick_command_ramp_watchdog
	import scrw_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  item_valid,
	output logic                  item_ready,
	input  logic                  operation,
	input  logic [7:0]            payload_length,
	input  logic signed [7:0]     left_command,
	input  logic signed [7:0]     right_command,
	input  logic [7:0]            check_byte,
	output logic                  result_valid,
	input  logic                  result_ready,
	output logic signed [Q_W-1:0] left_drive,
	output logic signed [Q_W-1:0] right_drive,
	output logic                  torque_enabled,
	output logic                  packet_accepted,
	output logic                  timeout_stop,
	input  logic                  cfg_write,
	input  logic [1:0]            cfg_index,
	input  logic [15:0]           cfg_data
);

	logic [14:0] slew_rate_q;
	logic [6:0]  deadzone_q;
	logic [15:0] timeout_q;

	logic                  valid_s1;
	logic                  op_s1;
	logic [7:0]            len_s1;
	logic [7:0]            lcmd_s1;
	logic [7:0]            rcmd_s1;
	logic [7:0]            chk_s1;

	logic                  valid_s2;
	logic signed [Q_W-1:0] left_s2;
	logic signed [Q_W-1:0] right_s2;
	logic                  torque_s2;
	logic                  accepted_s2;
	logic                  stop_s2;

	logic signed [Q_W-1:0] goal_left_q;
	logic signed [Q_W-1:0] goal_right_q;
	logic signed [Q_W-1:0] level_left_q;
	logic signed [Q_W-1:0] level_right_q;
	logic                  torque_q;
	logic                  armed_q;
	logic [15:0]           ticks_q;

	logic                  advance;
	pkt_res_t              pkt;
	logic signed [Q_W-1:0] slew_left;
	logic signed [Q_W-1:0] slew_right;
	logic [16:0]           ticks_inc;
	logic                  stop;

	logic signed [Q_W-1:0] goal_left_d;
	logic signed [Q_W-1:0] goal_right_d;
	logic signed [Q_W-1:0] level_left_d;
	logic signed [Q_W-1:0] level_right_d;
	logic                  torque_d;
	logic                  armed_d;
	logic [15:0]           ticks_d;
	logic                  accepted_d;
	logic                  stop_d;

	assign advance    = valid_s1 && (!valid_s2 || result_ready);
	assign item_ready = !valid_s1 || advance;

	scrw_packet u_packet (
		.payload_length (len_s1),
		.left_command   (lcmd_s1),
		.right_command  (rcmd_s1),
		.check_byte     (chk_s1),
		.deadzone       (deadzone_q),
		.res            (pkt)
	);

	scrw_slew u_slew_left (
		.level  (level_left_q),
		.goal   (goal_left_q),
		.step   (slew_rate_q),
		.result (slew_left)
	);

	scrw_slew u_slew_right (
		.level  (level_right_q),
		.goal   (goal_right_q),
		.step   (slew_rate_q),
		.result (slew_right)
	);

	assign ticks_inc = {1'b0, ticks_q} + 17'd1;
	assign stop      = armed_q && (ticks_inc > {1'b0, timeout_q});

	always_comb begin
		goal_left_d   = goal_left_q;
		goal_right_d  = goal_right_q;
		level_left_d  = level_left_q;
		level_right_d = level_right_q;
		torque_d      = torque_q;
		armed_d       = armed_q;
		ticks_d       = ticks_q;
		accepted_d    = 1'b0;
		stop_d        = 1'b0;
		if (op_s1 == OP_PACKET) begin
			if (pkt.accepted) begin
				goal_left_d  = pkt.goal_left;
				goal_right_d = pkt.goal_right;
				armed_d      = 1'b1;
				ticks_d      = '0;
				accepted_d   = 1'b1;
			end
		end else if (stop) begin
			goal_left_d   = '0;
			goal_right_d  = '0;
			level_left_d  = '0;
			level_right_d = '0;
			torque_d      = 1'b0;
			armed_d       = 1'b0;
			ticks_d       = '0;
			stop_d        = 1'b1;
		end else begin
			level_left_d  = slew_left;
			level_right_d = slew_right;
			torque_d      = torque_q || (slew_left != 0) || (slew_right != 0);
			if (armed_q)
				ticks_d = ticks_inc[15:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slew_rate_q <= SLEW_RATE_RST;
			deadzone_q  <= DEADZONE_RAW_RST;
			timeout_q   <= TIMEOUT_TICKS_RST;
		end else if (cfg_write) begin
			case (cfg_index)
				REG_SLEW_RATE:     slew_rate_q <= cfg_data[14:0];
				REG_DEADZONE_RAW:  deadzone_q  <= cfg_data[6:0];
				REG_TIMEOUT_TICKS: timeout_q   <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (item_ready)
				valid_s1 <= item_valid;
			if (advance)
				valid_s2 <= 1'b1;
			else if (result_ready)
				valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (item_valid && item_ready) begin
			op_s1   <= operation;
			len_s1  <= payload_length;
			lcmd_s1 <= left_command;
			rcmd_s1 <= right_command;
			chk_s1  <= check_byte;
		end
		if (advance) begin
			left_s2     <= level_left_d;
			right_s2    <= level_right_d;
			torque_s2   <= torque_d;
			accepted_s2 <= accepted_d;
			stop_s2     <= stop_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			goal_left_q   <= '0;
			goal_right_q  <= '0;
			level_left_q  <= '0;
			level_right_q <= '0;
			torque_q      <= 1'b0;
			armed_q       <= 1'b0;
			ticks_q       <= '0;
		end else if (advance) begin
			goal_left_q   <= goal_left_d;
			goal_right_q  <= goal_right_d;
			level_left_q  <= level_left_d;
			level_right_q <= level_right_d;
			torque_q      <= torque_d;
			armed_q       <= armed_d;
			ticks_q       <= ticks_d;
		end
	end

	assign result_valid    = valid_s2;
	assign left_drive      = left_s2;
	assign right_drive     = right_s2;
	assign torque_enabled  = torque_s2;
	assign packet_accepted = accepted_s2;
	assign timeout_stop    = stop_s2;

	// a stop clears the drives and torque it reports
	a_stop_clears: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && timeout_stop |->
			left_drive == 0 && right_drive == 0 && !torque_enabled)
		else $error("stop result with nonzero drive or torque");

	a_accept_xor_stop: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> !(packet_accepted && timeout_stop))
		else $error("packet accept and stop in one result");

	// disarmed watchdog keeps the count at zero
	a_disarmed_count: assert property (@(posedge clk) disable iff (!arst_n)
		!armed_q |-> ticks_q == 16'd0)
		else $error("tick count nonzero while disarmed");

	a_level_range: assert property (@(posedge clk) disable iff (!arst_n)
		level_left_q >= -16'sd16384 && level_left_q <= 16'sd16384 &&
		level_right_q >= -16'sd16384 && level_right_q <= 16'sd16384)
		else $error("level outside plus or minus one");

endmodule

// ===== test/stick_command_ramp_watchdog_test.sv =====
`timescale 1ns / 1ps
module stick_command_ramp_watchdog_test;
	import scrw_pkg::*;

	typedef struct packed {
		logic signed [Q_W-1:0] l_drive;
		logic signed [Q_W-1:0] r_drive;
		logic                  torque;
		logic                  accepted;
		logic                  stopped;
	} drive_res_t;

	logic                  clk;
	logic                  arst_n = 1'b0;
	logic                  item_valid = 1'b0;
	logic                  item_ready;
	logic                  operation = 1'b0;
	logic [7:0]            payload_length = '0;
	logic signed [7:0]     left_command = '0;
	logic signed [7:0]     right_command = '0;
	logic [7:0]            check_byte = '0;
	logic                  result_valid;
	logic                  result_ready = 1'b0;
	logic signed [Q_W-1:0] left_drive;
	logic signed [Q_W-1:0] right_drive;
	logic                  torque_enabled;
	logic                  packet_accepted;
	logic                  timeout_stop;
	logic                  cfg_write = 1'b0;
	logic [1:0]            cfg_index = '0;
	logic [15:0]           cfg_data = '0;

	// predicted block state and registers
	logic signed [Q_W-1:0] goal_l = '0;
	logic signed [Q_W-1:0] goal_r = '0;
	logic signed [Q_W-1:0] lvl_l = '0;
	logic signed [Q_W-1:0] lvl_r = '0;
	logic                  torque_state = 1'b0;
	logic                  watchdog_on = 1'b0;
	logic [15:0]           tick_count = '0;
	logic [14:0]           step_reg = SLEW_RATE_RST;
	logic [6:0]            dz_reg = DEADZONE_RAW_RST;
	logic [15:0]           timeout_reg = TIMEOUT_TICKS_RST;

	drive_res_t  drive_expected[$];
	drive_res_t  want;
	int          mismatches = 0;
	int unsigned burst_left = 0;
	int unsigned stall_left = 0;
	logic        no_idle = 1'b0;

	stick_command_ramp_watchdog DUT (
		.clk             (clk),
		.arst_n          (arst_n),
		.item_valid      (item_valid),
		.item_ready      (item_ready),
		.operation       (operation),
		.payload_length  (payload_length),
		.left_command    (left_command),
		.right_command   (right_command),
		.check_byte      (check_byte),
		.result_valid    (result_valid),
		.result_ready    (result_ready),
		.left_drive      (left_drive),
		.right_drive     (right_drive),
		.torque_enabled  (torque_enabled),
		.packet_accepted (packet_accepted),
		.timeout_stop    (timeout_stop),
		.cfg_write       (cfg_write),
		.cfg_index       (cfg_index),
		.cfg_data        (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	initial begin
		#5_000_000;
		$display("Simulation FAILED");
		$finish;
	end

	function automatic logic signed [Q_W-1:0] stick_level(logic [7:0] b, logic [6:0] dz);
		int m;
		int q;
		m = b[7] ? 256 - int'(b) : int'(b);
		if (m < int'(dz))
			return '0;
		q = (m * Q_ONE + 63) / 127;
		if (q > Q_ONE)
			q = Q_ONE;
		return b[7] ? Q_W'(-q) : Q_W'(q);
	endfunction

	function automatic logic signed [Q_W-1:0] slew_toward(logic signed [Q_W-1:0] lvl,
			logic signed [Q_W-1:0] goal, logic [14:0] step);
		int l;
		int g;
		l = lvl;
		g = goal;
		if (l < g) begin
			l += int'(step);
			if (l > g)
				l = g;
		end else if (l > g) begin
			l -= int'(step);
			if (l < g)
				l = g;
		end
		return Q_W'(l);
	endfunction

	task automatic send_item(input logic op, input logic [7:0] len, input logic [7:0] lft,
			input logic [7:0] rgt, input logic [7:0] chk);
		drive_res_t res;
		int         nxt;
		if (!no_idle && burst_left == 0) begin
			item_valid <= 1'b0;
			repeat (($urandom_range(0, 9) == 0) ? $urandom_range(10, 30) : $urandom_range(1, 6))
				@(posedge clk);
			burst_left = $urandom_range(1, 16);
		end
		if (burst_left != 0)
			burst_left--;
		item_valid     <= 1'b1;
		operation      <= op;
		payload_length <= len;
		left_command   <= lft;
		right_command  <= rgt;
		check_byte     <= chk;
		do
			@(posedge clk);
		while (!item_ready);
		res = '0;
		if (op == OP_PACKET) begin
			if (len == PACKET_LEN && (lft ^ rgt) == chk) begin
				goal_l       = stick_level(lft, dz_reg);
				goal_r       = stick_level(rgt, dz_reg);
				watchdog_on  = 1'b1;
				tick_count   = '0;
				res.accepted = 1'b1;
			end
		end else begin
			lvl_l = slew_toward(lvl_l, goal_l, step_reg);
			lvl_r = slew_toward(lvl_r, goal_r, step_reg);
			if (lvl_l != 0 || lvl_r != 0)
				torque_state = 1'b1;
			if (watchdog_on) begin
				nxt = int'(tick_count) + 1;
				if (nxt > int'(timeout_reg)) begin
					goal_l       = '0;
					goal_r       = '0;
					lvl_l        = '0;
					lvl_r        = '0;
					torque_state = 1'b0;
					watchdog_on  = 1'b0;
					tick_count   = '0;
					res.stopped  = 1'b1;
				end else begin
					tick_count = 16'(nxt);
				end
			end
		end
		res.l_drive = lvl_l;
		res.r_drive = lvl_r;
		res.torque  = torque_state;
		drive_expected.push_back(res);
	endtask

	task automatic send_packet(input logic [7:0] lft, input logic [7:0] rgt);
		send_item(OP_PACKET, PACKET_LEN, lft, rgt, lft ^ rgt);
	endtask

	task automatic send_ticks(input int n);
		repeat (n)
			send_item(OP_TICK, 8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
	endtask

	task automatic write_register(input logic [1:0] idx, input logic [15:0] value);
		item_valid <= 1'b0;
		while (drive_expected.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
		cfg_write <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= value;
		@(posedge clk);
		cfg_write <= 1'b0;
		case (idx)
			REG_SLEW_RATE:     step_reg = value[14:0];
			REG_DEADZONE_RAW:  dz_reg = value[6:0];
			REG_TIMEOUT_TICKS: timeout_reg = value;
			default: ;
		endcase
	endtask

	task automatic test_directed_packets();
		send_packet(8'h7F, 8'h80);
		send_ticks(3);
		send_packet(8'h06, 8'hFA);
		send_packet(8'h07, 8'hF9);
		send_ticks(2);
		send_packet(8'h00, 8'h00);
		// length and checksum rejects
		send_item(OP_PACKET, 8'd0, 8'h40, 8'h40, 8'h00);
		send_item(OP_PACKET, 8'd2, 8'h12, 8'h34, 8'h26);
		send_item(OP_PACKET, 8'd4, 8'h12, 8'h34, 8'h26);
		send_item(OP_PACKET, 8'd250, 8'hC0, 8'h3F, 8'hFF);
		send_item(OP_PACKET, 8'hFF, 8'hAA, 8'h55, 8'hFF);
		send_item(OP_PACKET, PACKET_LEN, 8'h40, 8'h20, 8'h61);
		send_item(OP_PACKET, PACKET_LEN, 8'h7F, 8'h80, 8'h00);
		send_ticks(2);
		send_packet(8'h81, 8'h01);
		send_ticks(4);
		send_packet(8'hFF, 8'h55);
		send_ticks(2);
	endtask

	task automatic test_register_extremes();
		write_register(REG_SLEW_RATE, 16'd16384);
		send_packet(8'h7F, 8'h80);
		send_ticks(2);
		send_packet(8'h80, 8'h7F);
		send_ticks(3);
		write_register(REG_SLEW_RATE, 16'h7FFF);
		send_packet(8'h80, 8'h7F);
		send_ticks(2);
		send_packet(8'h7F, 8'h80);
		send_ticks(1);
		// zero step holds the levels
		write_register(REG_SLEW_RATE, 16'd0);
		send_packet(8'h40, 8'hC0);
		send_ticks(3);
		write_register(REG_SLEW_RATE, 16'd1);
		write_register(REG_DEADZONE_RAW, 16'd0);
		send_packet(8'h01, 8'hFF);
		send_ticks(3);
		write_register(REG_DEADZONE_RAW, 16'd127);
		send_packet(8'h7E, 8'h81);
		send_ticks(2);
		send_packet(8'h7F, 8'h80);
		send_ticks(1);
		// zero timeout stops on the first tick, later ticks are not counted
		write_register(REG_SLEW_RATE, SLEW_RATE_RST);
		write_register(REG_DEADZONE_RAW, DEADZONE_RAW_RST);
		write_register(REG_TIMEOUT_TICKS, 16'd0);
		send_packet(8'h30, 8'hD0);
		send_ticks(4);
		// timeout lowered below the running count
		write_register(REG_TIMEOUT_TICKS, 16'd20);
		send_packet(8'h50, 8'hB0);
		send_ticks(10);
		write_register(REG_TIMEOUT_TICKS, 16'd3);
		send_ticks(2);
		write_register(REG_TIMEOUT_TICKS, 16'hFFFF);
		send_packet(8'h20, 8'h60);
		send_ticks(5);
		write_register(REG_TIMEOUT_TICKS, TIMEOUT_TICKS_RST);
		send_packet(8'h7F, 8'h7F);
		send_ticks(52);
	endtask

	task automatic test_random_traffic();
		int unsigned kind;
		logic [7:0]  lft;
		logic [7:0]  rgt;
		logic [7:0]  len;
		logic [7:0]  chk;
		for (int ph = 0; ph < 10; ph++) begin
			case ($urandom_range(0, 5))
				0:       write_register(REG_SLEW_RATE, 16'd1);
				1:       write_register(REG_SLEW_RATE, 16'd16384);
				2:       write_register(REG_SLEW_RATE, 16'h7FFF);
				3:       write_register(REG_SLEW_RATE, 16'd0);
				default: write_register(REG_SLEW_RATE, 16'($urandom_range(1, 4000)));
			endcase
			case ($urandom_range(0, 3))
				0:       write_register(REG_DEADZONE_RAW, 16'd0);
				1:       write_register(REG_DEADZONE_RAW, 16'd127);
				default: write_register(REG_DEADZONE_RAW, 16'($urandom_range(0, 20)));
			endcase
			case ($urandom_range(0, 5))
				0:       write_register(REG_TIMEOUT_TICKS, 16'd0);
				1:       write_register(REG_TIMEOUT_TICKS, 16'hFFFF);
				2:       write_register(REG_TIMEOUT_TICKS, 16'($urandom_range(41, 300)));
				default: write_register(REG_TIMEOUT_TICKS, 16'($urandom_range(1, 40)));
			endcase
			no_idle = ($urandom_range(0, 3) == 0);
			repeat (62) begin
				kind = $urandom_range(0, 99);
				lft  = ($urandom_range(0, 3) == 0) ?
					(8'($urandom_range(0, 12)) ^ {8{1'($urandom_range(0, 1))}}) : 8'($urandom);
				rgt  = ($urandom_range(0, 3) == 0) ?
					(8'($urandom_range(0, 12)) ^ {8{1'($urandom_range(0, 1))}}) : 8'($urandom);
				if (kind < 60) begin
					send_ticks(1);
				end else if (kind < 90) begin
					send_packet(lft, rgt);
				end else begin
					len = (kind < 95) ? PACKET_LEN : 8'($urandom);
					chk = 8'($urandom);
					send_item(OP_PACKET, len, lft, rgt, chk);
				end
			end
			no_idle = 1'b0;
		end
	endtask

	// receiver stalls in runs of random length, but is always ready while no_idle is set
	always @(posedge clk) begin
		if (no_idle) begin
			result_ready <= 1'b1;
		end else if (stall_left == 0) begin
			stall_left = $urandom_range(1, 12);
			result_ready <= ($urandom_range(0, 2) != 0);
		end else begin
			stall_left--;
		end
	end

	always @(posedge clk) begin
		if (arst_n && result_valid && result_ready) begin
			if (drive_expected.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result: l=%0d r=%0d t=%0b a=%0b s=%0b",
						left_drive, right_drive, torque_enabled, packet_accepted, timeout_stop);
			end else begin
				want = drive_expected.pop_front();
				if (left_drive !== want.l_drive || right_drive !== want.r_drive ||
						torque_enabled !== want.torque || packet_accepted !== want.accepted ||
						timeout_stop !== want.stopped) begin
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch at %0t: exp l=%0d r=%0d t=%0b a=%0b s=%0b,",
							$realtime, want.l_drive, want.r_drive, want.torque, want.accepted,
							want.stopped, " got l=%0d r=%0d t=%0b a=%0b s=%0b",
							left_drive, right_drive, torque_enabled,
							packet_accepted, timeout_stop);
				end
			end
		end
	end

	initial begin
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed_packets();
		test_register_extremes();
		test_random_traffic();
		item_valid <= 1'b0;
		while (drive_expected.size() != 0)
			@(posedge clk);
		repeat (10) @(posedge clk);
		if (mismatches == 0 && drive_expected.size() == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule
